>>> rtl/fdss_pkg.sv
// Shared types, constants and lookup functions of the four-digit scan unit.
package fdss_pkg;

  // Field widths of the input and result transactions.
  localparam int NUMBER_W = 16;
  localparam int SEG_W    = 7;
  localparam int SEL_W    = 4;
  localparam int IDX_W    = 2;
  localparam int BCD_W    = 4;

  // Saturated value range used by the digit split.
  localparam int VALUE_W = 14;
  localparam int REM1_W  = 10;
  localparam int REM2_W  = 7;
  localparam logic [NUMBER_W-1:0] DISPLAY_MAX = 16'd9999;

  // Default depth of the queue between the front and back parts.
  localparam int FDSS_QUEUE_DEPTH = 2;

  // Frame indexes in scan order.
  localparam logic [IDX_W-1:0] IDX_THOU = 2'd0;
  localparam logic [IDX_W-1:0] IDX_HUND = 2'd1;
  localparam logic [IDX_W-1:0] IDX_TENS = 2'd2;
  localparam logic [IDX_W-1:0] IDX_ONES = 2'd3;

  // Active-low digit select codes.
  localparam logic [SEL_W-1:0] SEL_THOU = 4'he;
  localparam logic [SEL_W-1:0] SEL_HUND = 4'hd;
  localparam logic [SEL_W-1:0] SEL_TENS = 4'hb;
  localparam logic [SEL_W-1:0] SEL_ONES = 4'h7;

  // One converted number, as it waits in the queue.
  typedef struct packed {
    logic [BCD_W-1:0] thou;
    logic [BCD_W-1:0] hund;
    logic [BCD_W-1:0] tens;
    logic [BCD_W-1:0] ones;
    logic             overflow;
  } fdss_entry_t;

  // Write side of the queue, driven by the front part.
  typedef struct packed {
    logic        push;
    fdss_entry_t entry;
  } fdss_qwr_t;

  // Read side of the queue, seen by the back part.
  typedef struct packed {
    logic        not_empty;
    fdss_entry_t entry;
  } fdss_qrd_t;

  // Seven-segment pattern for a hex digit, bit0 = a to bit6 = g.
  function automatic logic [SEG_W-1:0] seg_lookup(input logic [BCD_W-1:0] digit);
    logic [SEG_W-1:0] seg;
    case (digit)
      4'h0: seg = 7'h3f;
      4'h1: seg = 7'h06;
      4'h2: seg = 7'h5b;
      4'h3: seg = 7'h4f;
      4'h4: seg = 7'h66;
      4'h5: seg = 7'h6d;
      4'h6: seg = 7'h7d;
      4'h7: seg = 7'h07;
      4'h8: seg = 7'h7f;
      4'h9: seg = 7'h6f;
      4'ha: seg = 7'h77;
      4'hb: seg = 7'h7c;
      4'hc: seg = 7'h39;
      4'hd: seg = 7'h5e;
      4'he: seg = 7'h79;
      default: seg = 7'h71;
    endcase
    return seg;
  endfunction

  // Active-low digit select for a frame index.
  function automatic logic [SEL_W-1:0] select_code(input logic [IDX_W-1:0] idx);
    logic [SEL_W-1:0] sel;
    case (idx)
      IDX_THOU: sel = SEL_THOU;
      IDX_HUND: sel = SEL_HUND;
      IDX_TENS: sel = SEL_TENS;
      default:  sel = SEL_ONES;
    endcase
    return sel;
  endfunction

endpackage

>>> rtl/fdss_in_if.sv
// Input channel interface: one binary number per transaction.
interface fdss_in_if
  import fdss_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [NUMBER_W-1:0] number;

  modport source(output valid, output number, input ready);
  modport sink(input valid, input number, output ready);
endinterface

>>> rtl/fdss_out_if.sv
// Result channel interface: one scan frame per transaction.
interface fdss_out_if
  import fdss_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [SEG_W-1:0] segments;
  logic [SEL_W-1:0] digit_select;
  logic [IDX_W-1:0] digit_index;
  logic             last_frame;
  logic             overflow;

  modport source(output valid, output segments, output digit_select, output digit_index,
                 output last_frame, output overflow, input ready);
  modport sink(input valid, input segments, input digit_select, input digit_index,
               input last_frame, input overflow, output ready);
endinterface

>>> rtl/fdss_front.sv
// Front part: accepts numbers, saturates them and splits them into decimal digits.
module fdss_front
  import fdss_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  fdss_in_if.sink   in_ch,
  input  logic      q_full,
  output fdss_qwr_t q_wr
);

  logic                a_valid_r;
  logic [BCD_W-1:0]    a_thou_r;
  logic [REM1_W-1:0]   a_rem_r;
  logic                a_ovf_r;

  logic                b_valid_r;
  logic [BCD_W-1:0]    b_thou_r;
  logic [BCD_W-1:0]    b_hund_r;
  logic [REM2_W-1:0]   b_rem_r;
  logic                b_ovf_r;

  logic                a_take;
  logic                b_take;

  logic                sat_ovf;
  logic [VALUE_W-1:0]  sat_value;
  logic [BCD_W-1:0]    thou_digit;
  logic [REM1_W-1:0]   thou_rem;
  logic [BCD_W-1:0]    hund_digit;
  logic [REM2_W-1:0]   hund_rem;
  logic [BCD_W-1:0]    tens_digit;
  logic [BCD_W-1:0]    ones_digit;

  // Stall control: a stage takes new data when empty or when it moves on.
  assign b_take      = !b_valid_r || !q_full;
  assign a_take      = !a_valid_r || b_take;
  assign in_ch.ready = a_take;

  // Saturation and thousands digit by parallel compares.
  always_comb begin
    sat_ovf    = in_ch.number > DISPLAY_MAX;
    sat_value  = sat_ovf ? VALUE_W'(DISPLAY_MAX) : in_ch.number[VALUE_W-1:0];
    thou_digit = '0;
    for (int k = 1; k < 10; k++) begin
      if (sat_value >= VALUE_W'(k * 1000)) begin
        thou_digit = BCD_W'(k);
      end
    end
    thou_rem = REM1_W'(sat_value - VALUE_W'(32'(thou_digit) * 1000));
  end

  // Hundreds digit from the first remainder.
  always_comb begin
    hund_digit = '0;
    for (int k = 1; k < 10; k++) begin
      if (a_rem_r >= REM1_W'(k * 100)) begin
        hund_digit = BCD_W'(k);
      end
    end
    hund_rem = REM2_W'(a_rem_r - REM1_W'(32'(hund_digit) * 100));
  end

  // Tens and ones from the second remainder.
  always_comb begin
    tens_digit = '0;
    for (int k = 1; k < 10; k++) begin
      if (b_rem_r >= REM2_W'(k * 10)) begin
        tens_digit = BCD_W'(k);
      end
    end
    ones_digit = BCD_W'(b_rem_r - REM2_W'(32'(tens_digit) * 10));
  end

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_take) begin
        a_valid_r <= in_ch.valid;
      end
      if (b_take) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (a_take) begin
      a_thou_r <= thou_digit;
      a_rem_r  <= thou_rem;
      a_ovf_r  <= sat_ovf;
    end
    if (b_take) begin
      b_thou_r <= a_thou_r;
      b_hund_r <= hund_digit;
      b_rem_r  <= hund_rem;
      b_ovf_r  <= a_ovf_r;
    end
  end

  // Finished entries go into the queue when it has room.
  always_comb begin
    q_wr.push           = b_valid_r && !q_full;
    q_wr.entry.thou     = b_thou_r;
    q_wr.entry.hund     = b_hund_r;
    q_wr.entry.tens     = tens_digit;
    q_wr.entry.ones     = ones_digit;
    q_wr.entry.overflow = b_ovf_r;
  end

endmodule

>>> rtl/fdss_queue.sv
// Short FIFO of converted numbers between the front and back parts.
module fdss_queue
  import fdss_pkg::*;
#(
  parameter int DEPTH = FDSS_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  fdss_qwr_t q_wr,
  input  logic      pop,
  output logic      full,
  output fdss_qrd_t q_rd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fdss_entry_t        mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               do_pop;

  assign full           = count_r == CNT_W'(DEPTH);
  assign q_rd.not_empty = count_r != '0;
  assign q_rd.entry     = mem_r[rd_ptr_r];
  assign do_pop         = pop && q_rd.not_empty;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (q_wr.push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (q_wr.push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !q_wr.push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      mem_r[wr_ptr_r] <= q_wr.entry;
    end
  end

endmodule

>>> rtl/fdss_back.sv
// Back part: walks each queued number through its four scan frames.
module fdss_back
  import fdss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  fdss_qrd_t   q_rd,
  output logic        pop,
  fdss_out_if.source  out_ch
);

  logic [IDX_W-1:0] frame_r;
  logic             out_valid_r;
  logic [SEG_W-1:0] seg_r;
  logic [SEL_W-1:0] sel_r;
  logic [IDX_W-1:0] idx_r;
  logic             last_r;
  logic             ovf_r;
  logic             load;
  logic [BCD_W-1:0] cur_digit;

  // The output register reloads when empty or when its frame is taken.
  assign load = !out_valid_r || out_ch.ready;
  assign pop  = load && q_rd.not_empty && (frame_r == IDX_ONES);

  // Digit of the head entry for the current frame.
  always_comb begin
    case (frame_r)
      IDX_THOU: cur_digit = q_rd.entry.thou;
      IDX_HUND: cur_digit = q_rd.entry.hund;
      IDX_TENS: cur_digit = q_rd.entry.tens;
      default:  cur_digit = q_rd.entry.ones;
    endcase
  end

  // Frame counter and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r     <= IDX_THOU;
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= q_rd.not_empty;
      if (q_rd.not_empty) begin
        frame_r <= frame_r + 1'b1;
      end
    end
  end

  // Output frame payload.
  always_ff @(posedge clk) begin
    if (load && q_rd.not_empty) begin
      seg_r  <= seg_lookup(cur_digit);
      sel_r  <= select_code(frame_r);
      idx_r  <= frame_r;
      last_r <= frame_r == IDX_ONES;
      ovf_r  <= q_rd.entry.overflow;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.segments     = seg_r;
  assign out_ch.digit_select = sel_r;
  assign out_ch.digit_index  = idx_r;
  assign out_ch.last_frame   = last_r;
  assign out_ch.overflow     = ovf_r;

endmodule

>>> rtl/four_digit_seven_segment_scan_unit.sv
// Four-digit seven-segment scan unit: binary number in, four digit frames out.
//
// in_ch takes one 16-bit number per transaction; out_ch gives four frames per
// number, thousands first and ones last, each with its segment pattern,
// active-low digit select, frame index and the overflow flag. The ones frame
// has last_frame set. Numbers above 9999 show as 9999 with overflow set.
// The first frame of a number passes front stages a and b, the queue and the
// output register; the other three follow one per cycle when not stalled.
// The single output register sends one frame per cycle when not stalled. The
// front converts one number per cycle while the queue has room, in a two-stage
// compare pipeline, and parks the digits in a small queue, so it keeps
// accepting numbers while the back part is still sending earlier frames.
// When the receiver holds out_ch.ready low the current frame holds steady; the
// queue fills and then in_ch.ready drops. Synchronous reset empties the
// pipeline, the queue and the output register; nothing else needs clearing.
module four_digit_seven_segment_scan_unit
  import fdss_pkg::*;
#(
  parameter int QUEUE_DEPTH = FDSS_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  fdss_in_if.sink    in_ch,
  fdss_out_if.source out_ch
);

  fdss_qwr_t q_wr;
  fdss_qrd_t q_rd;
  logic      q_full;
  logic      q_pop;

  // Conversion pipeline.
  fdss_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_wr   (q_wr)
  );

  // Digit queue.
  fdss_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .q_wr  (q_wr),
    .pop   (q_pop),
    .full  (q_full),
    .q_rd  (q_rd)
  );

  // Frame sequencer and output register.
  fdss_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_rd   (q_rd),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

endmodule

>>> rtl/fdss_checker.sv
// Port-level checks of the scan unit's frame stream, bound to the top level.
module fdss_checker
  import fdss_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [SEG_W-1:0] segments,
  input logic [SEL_W-1:0] digit_select,
  input logic [IDX_W-1:0] digit_index,
  input logic             last_frame,
  input logic             overflow
);

  logic [IDX_W-1:0] exp_idx_r;

  // Expected index of the next frame, advanced on every transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_idx_r <= IDX_THOU;
    end else if (out_valid && out_ready) begin
      exp_idx_r <= exp_idx_r + 1'b1;
    end
  end

  // A stalled frame stays put.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(segments) && $stable(digit_index))
    else $error("frame changed while stalled");

  // Frames run thousands to ones without gaps or repeats.
  a_frame_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> digit_index == exp_idx_r)
    else $error("frame out of order");

  // Select code and last flag agree with the frame index.
  a_select_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (last_frame == (digit_index == IDX_ONES)) &&
                  ((digit_index == IDX_THOU && digit_select == SEL_THOU) ||
                   (digit_index == IDX_HUND && digit_select == SEL_HUND) ||
                   (digit_index == IDX_TENS && digit_select == SEL_TENS) ||
                   (digit_index == IDX_ONES && digit_select == SEL_ONES)))
    else $error("select or last flag mismatch");

  // A saturated number shows nine on every digit.
  a_overflow_nine: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && overflow |-> segments == seg_lookup(4'h9))
    else $error("overflow frame not showing nine");

endmodule

bind four_digit_seven_segment_scan_unit fdss_checker u_fdss_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .segments     (out_ch.segments),
  .digit_select (out_ch.digit_select),
  .digit_index  (out_ch.digit_index),
  .last_frame   (out_ch.last_frame),
  .overflow     (out_ch.overflow)
);
